// ===== hdl/motsm_pkg.sv =====
// ----------------------------------------------------------------------------
// motsm_pkg
// Shared types, widths and helpers for the motion smoothing low-pass unit.
// ----------------------------------------------------------------------------
package motsm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int STATE_W  = 40;
  localparam int GUARD_W  = STATE_W - SAMPLE_W;
  localparam int POLE_W   = 16;
  localparam int DELAY_W  = 6;
  localparam int CFG_W    = 16;

  localparam logic [POLE_W-1:0]  POLE_RESET  = 16'd62000;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 6'd0;

  localparam logic CFG_POLE  = 1'b0;
  localparam logic CFG_DELAY = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_x;
    logic signed [SAMPLE_W-1:0] sample_y;
    logic                       seq_end;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smooth_x;
    logic signed [SAMPLE_W-1:0] smooth_y;
    logic signed [SAMPLE_W-1:0] jitter_x;
    logic signed [SAMPLE_W-1:0] jitter_y;
    logic                       final_item;
    logic                       too_short;
  } out_t;

  // saturate one extra bit down to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat17(input logic signed [SAMPLE_W:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
      r = v[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/motsm_serial_mul.sv =====
// ----------------------------------------------------------------------------
// motsm_serial_mul
// Bit-serial signed by unsigned multiplier, one pole bit per cycle.
// ----------------------------------------------------------------------------
module motsm_serial_mul (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  input  logic signed [motsm_pkg::STATE_W:0]        a_i,
  input  logic        [motsm_pkg::POLE_W-1:0]       b_i,
  output logic                                      done_o,
  output logic signed [motsm_pkg::STATE_W+motsm_pkg::POLE_W:0] prod_o
);
  import motsm_pkg::*;

  localparam int AW = STATE_W + 1;
  localparam int PW = AW + POLE_W;
  localparam int CNW = $clog2(POLE_W + 1);

  logic signed [AW-1:0]     a_q;
  logic        [POLE_W-1:0] b_q;
  logic signed [PW-1:0]     acc_q;
  logic        [CNW-1:0]    cnt_q;
  logic                     busy_q, done_q;
  logic signed [PW:0]       sum;

  assign sum = {acc_q[PW-1], acc_q} +
               (b_q[0] ? {a_q[AW-1], a_q, {POLE_W{1'b0}}} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(POLE_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= sum[PW:1];
      b_q   <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hdl/motsm_serial_div.sv =====
// ----------------------------------------------------------------------------
// motsm_serial_div
// Restoring divider, one quotient bit per cycle, quotient truncated to zero.
// ----------------------------------------------------------------------------
module motsm_serial_div #(
  parameter int DIV_W = 6
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [motsm_pkg::SAMPLE_W-1:0] dividend_i,
  input  logic        [DIV_W-1:0]              divisor_i,
  output logic                                 done_o,
  output logic signed [motsm_pkg::SAMPLE_W-1:0] quot_o
);
  import motsm_pkg::*;

  localparam int CNW = $clog2(SAMPLE_W + 1);

  logic [SAMPLE_W-1:0] mag_q;
  logic [DIV_W-1:0]    rem_q;
  logic [DIV_W-1:0]    div_q;
  logic                neg_q;
  logic [CNW-1:0]      cnt_q;
  logic                busy_q, done_q;
  logic [DIV_W:0]      rem_sh;
  logic                qbit;

  assign rem_sh = {rem_q, mag_q[SAMPLE_W-1]};
  assign qbit   = (rem_sh >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(SAMPLE_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SAMPLE_W-1];
      mag_q <= dividend_i[SAMPLE_W-1] ? SAMPLE_W'(-dividend_i) : dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? DIV_W'(rem_sh - {1'b0, div_q}) : rem_sh[DIV_W-1:0];
      mag_q <= {mag_q[SAMPLE_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? SAMPLE_W'(-mag_q) : mag_q;

endmodule

// ===== hdl/motion_smoothing_lowpass_unit.sv =====
// ----------------------------------------------------------------------------
// motion_smoothing_lowpass_unit
// Four cascaded one-pole low-pass stages per axis with lag compensation
// from a raw sample line, jitter output and a linear tail on sequence end.
//
// channel | dir | handshake             | payload
// in      | in  | in_valid_i/in_ready_o | in_data_i  (motsm_pkg::in_t)
// out     | out | out_valid_o/out_ready_i | out_data_o (motsm_pkg::out_t)
// cfg     | in  | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// a frame with a data result runs from transfer to transfer through eight
// filter stages on the shared serial multiplier, then smooth, line read, emit
// and idle, or the tail on sequence end; a too-short result skips the line
// read; a frame with no result goes from smooth back to idle; the tail runs the
// serial division once, then a tail step, line read and emit per tail result
// reset clears filter, config and sequencer state; the raw line is not cleared
// a stalled output holds the sequencer in its emit step
// ----------------------------------------------------------------------------
module motion_smoothing_lowpass_unit #(
  parameter int MAX_DELAY = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  motsm_pkg::in_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output motsm_pkg::out_t      out_data_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [motsm_pkg::CFG_W-1:0] cfg_data_i
);
  import motsm_pkg::*;

  localparam int PW    = (MAX_DELAY < 2) ? 1 : $clog2(MAX_DELAY + 1);
  localparam int DEPTH = 2 ** PW;
  localparam int CW    = (PW > DELAY_W) ? PW : DELAY_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FILT   = 7'b0000010,
    S_SMOOTH = 7'b0000100,
    S_RD     = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_TAIL   = 7'b1000000
  } state_e;

  state_e state_q;

  logic [POLE_W-1:0]  pole_q;
  logic [DELAY_W-1:0] delay_q;

  logic signed [STATE_W-1:0] hist_q [2][4];
  logic signed [STATE_W-1:0] t_q;
  logic                      ax_q;
  logic [1:0]                st_q;
  logic                      launch_q;

  logic [2*SAMPLE_W-1:0] line_q [DEPTH];
  logic [2*SAMPLE_W-1:0] rdata_q;
  logic [PW-1:0]         rd_addr_q;
  logic [PW-1:0]         wr_ptr_q;
  logic [6:0]            frames_q;

  logic signed [SAMPLE_W-1:0] y_in_q;
  logic                       last_q;
  logic [PW-1:0]              d_q;
  logic [PW-1:0]              i_q;
  logic                       fin_q, err_q, tail_q;
  logic signed [SAMPLE_W-1:0] cur_x_q, cur_y_q, qx_q, qy_q;

  logic   out_valid_q;
  out_t   out_q;

  logic                             mul_start;
  logic signed [STATE_W:0]          mul_a;
  logic                             mul_done;
  logic signed [STATE_W+POLE_W:0]   mul_p;
  logic signed [STATE_W:0]          mul_rnd;
  logic signed [STATE_W-1:0]        h_new;

  logic                       div_start, divx_done, divy_done;
  logic signed [SAMPLE_W-1:0] qx, qy;

  logic signed [STATE_W:0]    sx_sum, sy_sum;
  logic signed [SAMPLE_W-1:0] sx, sy;
  logic signed [SAMPLE_W:0]   jx, jy;
  logic                       accept, emit_go;
  logic [CW-1:0]              d_full;

  assign accept  = in_valid_i && in_ready_o;
  assign emit_go = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign d_full  = CW'(delay_q);

  // shared filter multiplier: pole*(h-t)
  assign mul_start = (state_q == S_FILT) && launch_q;
  assign mul_a     = {hist_q[ax_q][st_q][STATE_W-1], hist_q[ax_q][st_q]} -
                     {t_q[STATE_W-1], t_q};
  assign mul_rnd   = (STATE_W+1)'((mul_p + (STATE_W+POLE_W+1)'(32768)) >>> POLE_W);
  assign h_new     = STATE_W'(mul_rnd + {t_q[STATE_W-1], t_q});

  motsm_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (pole_q),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  assign div_start = emit_go && !err_q && !fin_q && last_q && !tail_q;

  motsm_serial_div #(.DIV_W(PW)) u_divx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur_x_q),
    .divisor_i  (d_q),
    .done_o     (divx_done),
    .quot_o     (qx)
  );

  motsm_serial_div #(.DIV_W(PW)) u_divy (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cur_y_q),
    .divisor_i  (d_q),
    .done_o     (divy_done),
    .quot_o     (qy)
  );

  assign sx_sum = {hist_q[0][3][STATE_W-1], hist_q[0][3]} + (STATE_W+1)'(1 << (GUARD_W - 1));
  assign sy_sum = {hist_q[1][3][STATE_W-1], hist_q[1][3]} + (STATE_W+1)'(1 << (GUARD_W - 1));
  assign sx     = sat17(sx_sum[STATE_W:GUARD_W]);
  assign sy     = sat17(sy_sum[STATE_W:GUARD_W]);
  assign jx     = {rdata_q[2*SAMPLE_W-1], rdata_q[2*SAMPLE_W-1:SAMPLE_W]} -
                  {cur_x_q[SAMPLE_W-1], cur_x_q};
  assign jy     = {rdata_q[SAMPLE_W-1], rdata_q[SAMPLE_W-1:0]} -
                  {cur_y_q[SAMPLE_W-1], cur_y_q};

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_q  <= POLE_RESET;
      delay_q <= DELAY_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLE:  pole_q  <= cfg_data_i[POLE_W-1:0];
        CFG_DELAY: delay_q <= cfg_data_i[DELAY_W-1:0];
        default:   pole_q  <= pole_q;
      endcase
    end
  end

  // raw sample line
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_q[wr_ptr_q] <= {in_data_i.sample_x, in_data_i.sample_y};
    end
    rdata_q <= line_q[rd_addr_q];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      ax_q        <= 1'b0;
      st_q        <= '0;
      wr_ptr_q    <= '0;
      frames_q    <= '0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        for (int s = 0; s < 4; s++) begin
          hist_q[a][s] <= '0;
        end
      end
    end else begin
      if (out_valid_q && out_ready_i && !emit_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            t_q      <= {in_data_i.sample_x, {GUARD_W{1'b0}}};
            y_in_q   <= in_data_i.sample_y;
            last_q   <= in_data_i.seq_end;
            d_q      <= (d_full > CW'(MAX_DELAY)) ? PW'(MAX_DELAY) : d_full[PW-1:0];
            frames_q <= (frames_q == 7'd127) ? 7'd127 : frames_q + 7'd1;
            ax_q     <= 1'b0;
            st_q     <= '0;
            launch_q <= 1'b1;
            tail_q   <= 1'b0;
            state_q  <= S_FILT;
          end
        end
        S_FILT: begin
          if (launch_q) begin
            launch_q <= 1'b0;
          end else if (mul_done) begin
            hist_q[ax_q][st_q] <= h_new;
            if (st_q == 2'd3) begin
              st_q <= '0;
              if (ax_q) begin
                state_q <= S_SMOOTH;
              end else begin
                launch_q <= 1'b1;
                ax_q     <= 1'b1;
                t_q      <= {y_in_q, {GUARD_W{1'b0}}};
              end
            end else begin
              launch_q <= 1'b1;
              st_q     <= st_q + 2'd1;
              t_q      <= h_new;
            end
          end
        end
        S_SMOOTH: begin
          cur_x_q <= sx;
          cur_y_q <= sy;
          if (9'(frames_q) > 9'(d_q)) begin
            rd_addr_q <= wr_ptr_q - d_q;
            fin_q     <= last_q && (d_q == '0);
            err_q     <= 1'b0;
            state_q   <= S_RD;
          end else if (last_q) begin
            fin_q   <= 1'b1;
            err_q   <= 1'b1;
            state_q <= S_EMIT;
          end else begin
            wr_ptr_q <= wr_ptr_q + PW'(1);
            state_q  <= S_IDLE;
          end
        end
        S_RD: begin
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_q         <= 1'b1;
            out_q.smooth_x      <= err_q ? '0 : cur_x_q;
            out_q.smooth_y      <= err_q ? '0 : cur_y_q;
            out_q.jitter_x      <= err_q ? '0 : sat17(jx);
            out_q.jitter_y      <= err_q ? '0 : sat17(jy);
            out_q.final_item    <= fin_q;
            out_q.too_short     <= err_q;
            if (fin_q || err_q) begin
              wr_ptr_q <= '0;
              frames_q <= '0;
              for (int a = 0; a < 2; a++) begin
                for (int s = 0; s < 4; s++) begin
                  hist_q[a][s] <= '0;
                end
              end
              state_q <= S_IDLE;
            end else if (tail_q) begin
              state_q <= S_TAIL;
            end else if (last_q) begin
              i_q     <= PW'(1);
              state_q <= S_DIV;
            end else begin
              wr_ptr_q <= wr_ptr_q + PW'(1);
              state_q  <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          if (divx_done && divy_done) begin
            qx_q    <= qx;
            qy_q    <= qy;
            state_q <= S_TAIL;
          end
        end
        S_TAIL: begin
          cur_x_q   <= cur_x_q - (tail_q ? qx_q : qx_q);
          cur_y_q   <= cur_y_q - qy_q;
          rd_addr_q <= wr_ptr_q - (d_q - i_q);
          fin_q     <= (i_q == d_q);
          i_q       <= i_q + PW'(1);
          tail_q    <= 1'b1;
          state_q   <= S_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_err_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.too_short |-> out_data_o.final_item)
    else $error("error result without final flag");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.too_short |->
      out_data_o.smooth_x == '0 && out_data_o.smooth_y == '0 &&
      out_data_o.jitter_x == '0 && out_data_o.jitter_y == '0)
    else $error("error result carries data");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second transfer while busy");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go && (fin_q || err_q) |=> wr_ptr_q == '0 && frames_q == '0)
    else $error("sequence state not cleared after final result");

endmodule
